/* rtl/core/kpc_pkg.sv */
`default_nettype none

package kpc_pkg;

  // Key kinds carried on the input channel's tuser
  typedef enum logic [2:0] {
    KEY_DIGIT  = 3'd0,
    KEY_ADD    = 3'd1,
    KEY_SUB    = 3'd2,
    KEY_MUL    = 3'd3,
    KEY_DIV    = 3'd4,
    KEY_EQUALS = 3'd5
  } key_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_OP    = 2'd1,
    ST_DIV_ZERO = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DONE
  } state_t;

  localparam int KEY_W   = 3;
  localparam int DIGIT_W = 4;
  localparam int STAT_W  = 2;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);
  localparam logic [DIGIT_W-1:0] DIGIT_MIN = DIGIT_W'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic key_digit;  // fold digit into entry
    logic key_op;     // latch entry as first operand, record operation
    logic start;      // set up the equals operation
    logic step;       // one multiply or divide iteration
    logic finish;     // load output register, clear calculator state
  } kpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic iterate;    // recorded operation needs the iterative unit
    logic last_step;  // current iteration is the final one
  } kpc_stat_t;

endpackage

`default_nettype wire

/* rtl/core/keypad_four_function_calculator.sv */
`default_nettype none

// Four-function keypad calculator. Each input transaction is one key event:
// in_tuser carries the key kind (digit, add, subtract, multiply, divide,
// equals) and in_tdata the digit. Digits 1 to 9 extend the entry as
// entry*10+digit, wrapping modulo 2^DATA_WIDTH; other digit values and unused
// key kinds are dropped. An operator key latches the entry as the first
// operand and records the operation; equals produces exactly one output
// transaction with the unsigned sum, wrapping difference, low half of the
// product or truncated quotient, then clears the entry, operand and
// operation. out_tuser reports status (0 ok, 1 no operator entered, 2
// divide by zero); the answer is zero whenever status is nonzero. Digit
// and operator keys are taken while idle. Equals with add, subtract, no
// operator or divide by zero goes straight to the done state, which registers
// the result; multiply and divide first run on one shared shift-add /
// restoring-divide unit that retires one bit per cycle. The result sits in
// an output register, so the next key is accepted while it waits.
module keypad_four_function_calculator
  import kpc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
)
(
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,  // [3:0] digit
  input  wire logic [KEY_W-1:0]                    in_tuser,  // [2:0] mode
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]  out_tdata, // answer
  output logic [STAT_W-1:0]                        out_tuser  // [1:0] status
);

  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  kpc_cmd_t              cmd;
  kpc_stat_t             dp_stat;
  key_t                  key;
  logic [DATA_WIDTH-1:0] answer;
  stat_t                 status;

  assign key = key_t'(in_tuser);

  // sequence key handling, iteration and output handshake
  kpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .key        (key),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .dp_stat    (dp_stat)
  );

  // entry, operands and the shared arithmetic unit
  kpc_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .key     (key),
    .digit   (in_tdata[DIGIT_W-1:0]),
    .cmd     (cmd),
    .dp_stat (dp_stat),
    .answer  (answer),
    .status  (status)
  );

  // zero-fill the answer up to whole bytes
  assign out_tdata = OUT_W'(answer);
  assign out_tuser = status;

endmodule

`default_nettype wire

/* rtl/core/kpc_ctrl.sv */
`default_nettype none

module kpc_ctrl
  import kpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire key_t      key,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output kpc_cmd_t       cmd,
  input  wire kpc_stat_t dp_stat
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = (state_r == S_IDLE);
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (key)
            KEY_DIGIT: cmd.key_digit = 1'b1;
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: cmd.key_op = 1'b1;
            KEY_EQUALS: begin
              cmd.start = 1'b1;
              state_nxt = dp_stat.iterate ? S_CALC : S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_CALC: begin
        cmd.step = 1'b1;
        if (dp_stat.last_step) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/kpc_dp.sv */
`default_nettype none

module kpc_dp
  import kpc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire key_t                  key,
  input  wire logic [DIGIT_W-1:0]    digit,
  input  wire kpc_cmd_t              cmd,
  output kpc_stat_t                  dp_stat,
  output logic [DATA_WIDTH-1:0]      answer,
  output stat_t                      status
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] entry_r, opa_r;
  key_t                  op_r;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] mcand_r, mcand_nxt;
  logic [DATA_WIDTH-1:0] shf_r, shf_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  stat_t                 stat_r, stat_nxt;
  logic [DATA_WIDTH-1:0] answer_r;
  stat_t                 status_r;

  logic [DATA_WIDTH-1:0] entry_x10;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   trial_diff;
  logic                  digit_ok;

  assign entry_x10  = (entry_r << 3) + (entry_r << 1) + DATA_WIDTH'(digit);
  assign digit_ok   = (digit >= DIGIT_MIN) && (digit <= DIGIT_MAX);
  assign trial      = {acc_r, shf_r[DATA_WIDTH-1]};
  assign trial_diff = trial - {1'b0, mcand_r};

  assign dp_stat.iterate   = (op_r == KEY_MUL) ||
                             ((op_r == KEY_DIV) && (entry_r != '0));
  assign dp_stat.last_step = (cnt_r == CW'(DATA_WIDTH - 1));

  // calculator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      opa_r   <= '0;
      op_r    <= KEY_DIGIT;
    end else if (cmd.finish) begin
      entry_r <= '0;
      opa_r   <= '0;
      op_r    <= KEY_DIGIT;
    end else if (cmd.key_op) begin
      opa_r   <= entry_r;
      entry_r <= '0;
      op_r    <= key;
    end else if (cmd.key_digit && digit_ok) begin
      entry_r <= entry_x10;
    end
  end

  // shared shift-add multiply / restoring divide unit
  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    shf_nxt   = shf_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    if (cmd.start) begin
      cnt_nxt  = '0;
      stat_nxt = ST_OK;
      unique case (op_r)
        KEY_ADD: acc_nxt = opa_r + entry_r;
        KEY_SUB: acc_nxt = opa_r - entry_r;
        KEY_MUL: begin
          acc_nxt   = '0;
          mcand_nxt = opa_r;
          shf_nxt   = entry_r;
        end
        KEY_DIV: begin
          acc_nxt   = '0;
          mcand_nxt = entry_r;
          if (entry_r == '0) begin
            shf_nxt  = '0;
            stat_nxt = ST_DIV_ZERO;
          end else begin
            shf_nxt = opa_r;
          end
        end
        default: begin
          acc_nxt  = '0;
          stat_nxt = ST_NO_OP;
        end
      endcase
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + CW'(1);
      if (op_r == KEY_MUL) begin
        if (shf_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r << 1;
        shf_nxt   = shf_r >> 1;
      end else begin
        if (!trial_diff[DATA_WIDTH]) begin
          acc_nxt = trial_diff[DATA_WIDTH-1:0];
          shf_nxt = {shf_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc_nxt = trial[DATA_WIDTH-1:0];
          shf_nxt = {shf_r[DATA_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    shf_r   <= shf_nxt;
    cnt_r   <= cnt_nxt;
    stat_r  <= stat_nxt;
    if (cmd.finish) begin
      answer_r <= (op_r == KEY_DIV) ? shf_r : acc_r;
      status_r <= stat_r;
    end
  end

  assign answer = answer_r;
  assign status = status_r;

endmodule

`default_nettype wire
